// ===== src/bnc3_pkg.sv =====
// ============================================================================
// bnc3_pkg
// Shared types and constants for the binary 3x3 neighbour counter.
// ============================================================================
package bnc3_pkg;

    // Field and register widths.
    localparam int WIDTH_W      = 6;
    localparam int HEIGHT_W     = 16;
    localparam int COUNT_W      = 4;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = HEIGHT_W;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 8;
    localparam int OUT_TUSER_W  = 2;

    // Default build and reset values.
    localparam int DEF_MAX_WIDTH = 32;
    localparam logic [WIDTH_W-1:0]  RST_FRAME_WIDTH  = WIDTH_W'(32);
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = HEIGHT_W'(32);

    // Largest possible count of set neighbours.
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(8);

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // Result slots of one pixel, in emission order.
    localparam int SLOT_ABOVE_PREV = 0;  // pixel up and left of the new one
    localparam int SLOT_ABOVE_LAST = 1;  // last column of the row above
    localparam int SLOT_CUR_PREV   = 2;  // pixel left of the new one, last row
    localparam int SLOT_CUR_LAST   = 3;  // final pixel of the frame
    localparam int NUM_SLOTS       = 4;
    localparam int SLOT_W          = 2;

    // Bit positions in the output tuser word.
    localparam int TUSER_ROW_END   = 0;
    localparam int TUSER_FRAME_END = 1;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_EMIT
    } state_t;

endpackage

// ===== src/binary_neighbour_count_3x3.sv =====
// ============================================================================
// binary_neighbour_count_3x3
// Streaming counter of set pixels in the 3x3 neighbourhood of a binary image.
// ============================================================================
//
// Channel   Dir  Word                                     Notes
// s_axis    in   tdata[0] pixel_set                       raster order
// m_axis    out  tdata[3:0] neighbour_count               tlast = run_last
//                tuser[0] row_end, tuser[1] frame_end
// cfg       in   cfg_index 0 frame_width, 1 frame_height  write only
//
// Each pixel goes through the line memory read as it is accepted, then the
// window update and write back, then one result word on m_axis for each
// result it releases (0 to 4).
// s_axis_tready is high only while the sequencer is idle.
// A stalled m_axis holds its word and keeps the input side closed.
// Reset clears positions and sets both frame sizes to 32; the line memory
// needs no clearing since rows above the frame are masked.
//
module binary_neighbour_count_3x3 #(
    parameter int MAX_WIDTH = bnc3_pkg::DEF_MAX_WIDTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Pixel input.
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [bnc3_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [0] pixel_set
    // Count output.
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [bnc3_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [3:0] neighbour_count
    output logic [bnc3_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,   // [0] row_end, [1] frame_end
    output logic                                 m_axis_tlast,
    // Configuration writes.
    input  logic                                 cfg_we,
    input  logic [bnc3_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [bnc3_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import bnc3_pkg::*;

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam logic [WIDTH_W-1:0] MAX_W_V = WIDTH_W'(MAX_WIDTH);

    // Sum of the bits of a window selected by a mask.
    function automatic logic [COUNT_W-1:0] masked_count(input logic [8:0] bits);
        logic [COUNT_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < 9; i++)
        begin
            sum = sum + COUNT_W'(bits[i]);
        end
        return sum;
    endfunction

    // Control state.
    state_t                 state_reg, state_next;
    logic [WIDTH_W-1:0]     width_reg;
    logic [HEIGHT_W-1:0]    height_reg;
    logic [COL_W-1:0]       col_reg;
    logic [HEIGHT_W-1:0]    row_reg;
    logic [NUM_SLOTS-1:0]   pend_reg, pend_next;

    // Payload state.
    logic                   px_reg;
    logic [1:0]             rd_data_reg;
    logic [2:0]             col0_reg, col1_reg, col2_reg;   // bit 0 top, bit 2 bottom
    logic [2:0]             col0_next, col1_next, col2_next;
    logic [COUNT_W-1:0]     cnt_reg [NUM_SLOTS];
    logic [COUNT_W-1:0]     cnt_next [NUM_SLOTS];

    // Line memory: bit 1 two rows up, bit 0 one row up.
    logic [1:0]             line_mem [MAX_WIDTH];

    logic                   in_accept;
    logic                   mem_we;
    logic [1:0]             mem_wdata;
    logic [WIDTH_W-1:0]     w_eff;
    logic [HEIGHT_W-1:0]    h_eff;
    logic                   last_col, last_row;
    logic                   row_ge1, row_ge2, col_ge1, col_ge2;
    logic [NUM_SLOTS-1:0]   sel_onehot;
    logic [SLOT_W-1:0]      sel_idx;
    logic                   sel_last;

    assign in_accept = s_axis_tvalid && s_axis_tready;

    // Effective frame sizes.
    always_comb
    begin
        if (width_reg == '0)
            w_eff = WIDTH_W'(1);
        else if (width_reg > MAX_W_V)
            w_eff = MAX_W_V;
        else
            w_eff = width_reg;
        h_eff = (height_reg == '0) ? HEIGHT_W'(1) : height_reg;
    end

    // Position decode.
    assign last_col = (WIDTH_W'(col_reg) == (w_eff - WIDTH_W'(1)));
    assign last_row = (row_reg == (h_eff - HEIGHT_W'(1)));
    assign row_ge1  = (row_reg != '0);
    assign row_ge2  = (row_reg > HEIGHT_W'(1));
    assign col_ge1  = (col_reg != '0);
    assign col_ge2  = (col_reg > COL_W'(1));

    // Window shift with columns left of the frame and rows above it forced clear.
    always_comb
    begin
        col2_next = {px_reg, row_ge1 & rd_data_reg[0], row_ge2 & rd_data_reg[1]};
        col1_next = col_ge1 ? col2_reg : 3'b000;
        col0_next = col_ge2 ? col1_reg : 3'b000;
    end

    // Counts for the four possible results, taken from the updated window.
    always_comb
    begin
        cnt_next[SLOT_ABOVE_PREV] = masked_count({col2_next, col1_next[2], col1_next[0],
                                                  col0_next, 1'b0});
        cnt_next[SLOT_ABOVE_LAST] = masked_count({3'b000, col2_next[2], col2_next[0],
                                                  col1_next, 1'b0});
        cnt_next[SLOT_CUR_PREV]   = masked_count({3'b000, col2_next[2], col2_next[1],
                                                  col1_next[1], col0_next[2:1], 1'b0});
        cnt_next[SLOT_CUR_LAST]   = masked_count({5'b00000, col2_next[1],
                                                  col1_next[2:1], 1'b0});
    end

    // Which results this pixel releases.
    always_comb
    begin
        pend_next = '0;
        pend_next[SLOT_ABOVE_PREV] = row_ge1 && col_ge1;
        pend_next[SLOT_ABOVE_LAST] = row_ge1 && last_col;
        pend_next[SLOT_CUR_PREV]   = last_row && col_ge1;
        pend_next[SLOT_CUR_LAST]   = last_row && last_col;
    end

    // Oldest pending result goes out first.
    always_comb
    begin
        sel_onehot = '0;
        sel_idx    = '0;
        priority if (pend_reg[SLOT_ABOVE_PREV])
        begin
            sel_onehot[SLOT_ABOVE_PREV] = 1'b1;
            sel_idx = SLOT_W'(SLOT_ABOVE_PREV);
        end
        else if (pend_reg[SLOT_ABOVE_LAST])
        begin
            sel_onehot[SLOT_ABOVE_LAST] = 1'b1;
            sel_idx = SLOT_W'(SLOT_ABOVE_LAST);
        end
        else if (pend_reg[SLOT_CUR_PREV])
        begin
            sel_onehot[SLOT_CUR_PREV] = 1'b1;
            sel_idx = SLOT_W'(SLOT_CUR_PREV);
        end
        else
        begin
            sel_onehot[SLOT_CUR_LAST] = 1'b1;
            sel_idx = SLOT_W'(SLOT_CUR_LAST);
        end
        sel_last = ((pend_reg & ~sel_onehot) == '0);
    end

    // Sequencer: read, update, then emit.
    always_comb
    begin
        state_next    = state_reg;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        mem_we        = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                mem_we     = 1'b1;
                state_next = (pend_next == '0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:
            begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready && sel_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output word.
    always_comb
    begin
        m_axis_tdata = OUT_TDATA_W'(cnt_reg[sel_idx]);
        m_axis_tuser = '0;
        m_axis_tuser[TUSER_ROW_END]   = sel_onehot[SLOT_ABOVE_LAST] |
                                        sel_onehot[SLOT_CUR_LAST];
        m_axis_tuser[TUSER_FRAME_END] = sel_onehot[SLOT_CUR_LAST];
        m_axis_tlast = sel_last;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            width_reg  <= RST_FRAME_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
            col_reg    <= '0;
            row_reg    <= '0;
            pend_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;

            // A register write restarts the frame.
            priority if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                    REG_FRAME_HEIGHT: height_reg <= cfg_data;
                    default:          ;
                endcase
                col_reg <= '0;
                row_reg <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + HEIGHT_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            else
            begin
                col_reg <= col_reg;
                row_reg <= row_reg;
            end

            // Pending result mask.
            if (state_reg == ST_UPDATE)
                pend_reg <= pend_next;
            else if (m_axis_tvalid && m_axis_tready)
                pend_reg <= pend_reg & ~sel_onehot;
        end
    end

    // Payload registers: pixel, window and counts.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            px_reg <= s_axis_tdata[0];
        if (state_reg == ST_UPDATE)
        begin
            col0_reg <= col0_next;
            col1_reg <= col1_next;
            col2_reg <= col2_next;
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Line memory, one read and one write port, registered read.
    assign mem_wdata = {row_ge1 & rd_data_reg[0], px_reg};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            line_mem[col_reg] <= mem_wdata;
        if (in_accept)
            rd_data_reg <= line_mem[col_reg];
    end

endmodule

// ===== src/bnc3_checker.sv =====
// ============================================================================
// bnc3_checker
// Port-level checks for the binary 3x3 neighbour counter.
// ============================================================================
module bnc3_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    input  logic                                 s_axis_tready,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [bnc3_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [3:0] neighbour_count
    input  logic [bnc3_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,   // [0] row_end, [1] frame_end
    input  logic                                 m_axis_tlast
);
    import bnc3_pkg::*;

    // The input side stays closed while results are being delivered.
    a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !s_axis_tready)
        else $error("input ready while a result word is pending");

    // An accepted pixel needs its update cycle before the next one.
    a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input ready directly after an accepted pixel");

    // Counts never exceed eight neighbours.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[COUNT_W-1:0] <= MAX_COUNT))
        else $error("neighbour count above eight");

    // The frame's last pixel is also a row end and the last of its run.
    a_frame_end_flags: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser[TUSER_FRAME_END]) |->
            (m_axis_tuser[TUSER_ROW_END] && m_axis_tlast))
        else $error("frame end without row end or run end");

    // A stalled result word holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
             && $stable(m_axis_tlast)))
        else $error("stalled result word changed");

endmodule

bind binary_neighbour_count_3x3 bnc3_checker u_bnc3_checker (.*);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the binary 3x3 neighbour counter. Pixels go in on
// s_axis; every count word on m_axis is compared with a software copy of the
// counter, which keeps its own line memory, window and frame position. A short
// table of hand-picked cases runs first, then random frames of random sizes
// under four mixes of input gaps and output back-pressure.
// ============================================================================
module testbench;
    import bnc3_pkg::*;

    localparam int MAX_W       = DEF_MAX_WIDTH;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 80;      // long output hold-off
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_PIXELS = 32;

    // One count word as it leaves the block.
    typedef struct packed {
        logic [COUNT_W-1:0] cnt;
        logic               row_end;
        logic               frame_end;
        logic               run_last;
    } count_word_t;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

    // One row of stimulus; a typed row carries its expected outcome.
    typedef struct packed {
        step_kind_t                kind;
        logic [CFG_INDEX_W-1:0]    idx;
        logic [CFG_DATA_W-1:0]     data;
        logic                      px;
        logic                      typed;
        logic                      has_word;
        count_word_t               word;
    } step_t;

    localparam count_word_t NO_WORD   = '0;
    // A 1x1 frame: the pixel has no neighbours and ends row, frame and run.
    localparam count_word_t LONE_WORD = '{4'd0, 1'b1, 1'b1, 1'b1};

    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_TDATA_W-1:0]      s_axis_tdata;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_TDATA_W-1:0]     m_axis_tdata;
    logic [OUT_TUSER_W-1:0]     m_axis_tuser;
    logic                       m_axis_tlast;
    logic                       cfg_we;
    logic [CFG_INDEX_W-1:0]     cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;

    binary_neighbour_count_3x3 i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Directed cases.
    step_t dir_steps [0:21] = '{
        // Top row of the default 32x32 frame: nothing can be counted yet.
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b1, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b0, 1'b1, 1'b0, NO_WORD},
        // Zero sizes act as 1x1: every pixel is a frame of its own.
        '{STEP_WRITE, REG_FRAME_WIDTH, 16'd0, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd0, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b1, 1'b1, LONE_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b0, 1'b1, 1'b1, LONE_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b1, 1'b1, LONE_WORD},
        // Oversized width saturates, tallest frame: still in the top row.
        '{STEP_WRITE, REG_FRAME_WIDTH, 16'd63, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'hFFFF, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b1, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b1, 1'b0, NO_WORD},
        // A full 3x3 frame of set pixels: the center sees all eight.
        '{STEP_WRITE, REG_FRAME_WIDTH, 16'd3, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_WRITE, REG_FRAME_HEIGHT, 16'd3, 1'b0, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD},
        '{STEP_PIXEL, REG_FRAME_WIDTH, 16'd0, 1'b1, 1'b0, 1'b0, NO_WORD}
    };

    // Software copy of the counter.
    logic [WIDTH_W-1:0]   pred_width  = RST_FRAME_WIDTH;
    logic [HEIGHT_W-1:0]  pred_height = RST_FRAME_HEIGHT;
    bit [1:0]             line_mem [0:MAX_W-1] = '{default: 2'b00};
    int                   pred_row = 0;
    int                   pred_col = 0;
    bit                   nb_win [0:2][0:2] = '{default: '{default: 1'b0}};

    count_word_t          count_expect_q [$];
    step_t                pixel_tags [$];

    int error_count   = 0;
    int words_checked = 0;
    int pixels_sent   = 0;
    int cfg_writes    = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    function automatic int clamp_width(input logic [WIDTH_W-1:0] w);
        if (w == '0)
            return 1;
        if (w > MAX_W)
            return MAX_W;
        return int'(w);
    endfunction

    function automatic int clamp_height(input logic [HEIGHT_W-1:0] h);
        return (h == '0) ? 1 : int'(h);
    endfunction

    // Set pixels around window position (cr, cc), center excluded.
    function automatic logic [COUNT_W-1:0] window_sum(input int cr, input int cc);
        logic [COUNT_W-1:0] sum;
        sum = '0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (!(dr == 0 && dc == 0) && cr + dr >= 0 && cr + dr <= 2 &&
                    cc + dc >= 0 && cc + dc <= 2)
                    sum += COUNT_W'(nb_win[cr + dr][cc + dc]);
        return sum;
    endfunction

    // Advance the counter by one pixel and queue the words it releases.
    function automatic void count_neighbours(input bit px, input bit queue_words);
        int          w;
        int          h;
        int          r;
        int          c;
        int          n;
        bit [1:0]    old;
        bit          last_col;
        bit          last_row;
        count_word_t words [0:3];
        w = clamp_width(pred_width);
        h = clamp_height(pred_height);
        r = (pred_row >= h) ? 0 : pred_row;
        c = (pred_col >= w) ? 0 : pred_col;
        n = 0;
        old = line_mem[c];

        // Shift the window left and load the new column stack.
        for (int k = 0; k < 3; k++)
        begin
            nb_win[k][0] = nb_win[k][1];
            nb_win[k][1] = nb_win[k][2];
        end
        nb_win[0][2] = (r >= 2) ? old[1] : 1'b0;
        nb_win[1][2] = (r >= 1) ? old[0] : 1'b0;
        nb_win[2][2] = px;
        if (c < 2)
        begin
            nb_win[0][0] = 1'b0;
            nb_win[1][0] = 1'b0;
            nb_win[2][0] = 1'b0;
        end
        if (c < 1)
        begin
            nb_win[0][1] = 1'b0;
            nb_win[1][1] = 1'b0;
            nb_win[2][1] = 1'b0;
        end
        line_mem[c] = {old[0], px};

        last_col = (c == w - 1);
        last_row = (r == h - 1);
        if (r >= 1 && c >= 1)
        begin
            words[n] = '{window_sum(1, 1), 1'b0, 1'b0, 1'b0};
            n++;
        end
        if (r >= 1 && last_col)
        begin
            words[n] = '{window_sum(1, 2), 1'b1, 1'b0, 1'b0};
            n++;
        end
        if (last_row && c >= 1)
        begin
            words[n] = '{window_sum(2, 1), 1'b0, 1'b0, 1'b0};
            n++;
        end
        if (last_row && last_col)
        begin
            words[n] = '{window_sum(2, 2), 1'b1, 1'b1, 1'b0};
            n++;
        end
        for (int k = 0; k < n; k++)
        begin
            words[k].run_last = (k == n - 1);
            if (queue_words)
                count_expect_q.push_back(words[k]);
        end

        // Step to the next raster position.
        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        pred_row = r;
        pred_col = c;
    endfunction

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d words still expected",
                     $time, cycle_count, count_expect_q.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls plus requested long hold-offs.
    initial
    begin
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_left == 0 && hold_requests != hold_served)
            begin
                hold_served++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Sample handshakes: check words out, track writes and pixels in.
    always @(posedge clk)
    begin : monitor
        step_t       tag;
        count_word_t seen;
        count_word_t want;
        string       want_s;
        string       seen_s;
        if (rst_n)
        begin
            // Words leaving first, so a word never matches a pixel of this edge.
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen = '{m_axis_tdata[COUNT_W-1:0], m_axis_tuser[TUSER_ROW_END],
                         m_axis_tuser[TUSER_FRAME_END], m_axis_tlast};
                if (count_expect_q.size() == 0)
                begin
                    error_count++;
                    if (error_count <= 20)
                        $display("%0t: expected no word, got tdata=%h tuser=%b tlast=%b",
                                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = count_expect_q.pop_front();
                    words_checked++;
                    if (seen !== want || m_axis_tdata[OUT_TDATA_W-1:COUNT_W] !== '0)
                    begin
                        error_count++;
                        if (error_count <= 20)
                        begin
                            want_s = $sformatf("count=%0d row_end=%b frame_end=%b last=%b",
                                               want.cnt, want.row_end, want.frame_end,
                                               want.run_last);
                            seen_s = $sformatf("tdata=%h row_end=%b frame_end=%b last=%b",
                                               m_axis_tdata, seen.row_end, seen.frame_end,
                                               seen.run_last);
                            $display("%0t: mismatch: expected %s, got %s",
                                     $time, want_s, seen_s);
                        end
                    end
                end
            end

            // A write restarts the frame at the top left.
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    pred_width = cfg_data[WIDTH_W-1:0];
                else if (cfg_index == REG_FRAME_HEIGHT)
                    pred_height = cfg_data[HEIGHT_W-1:0];
                pred_row = 0;
                pred_col = 0;
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                tag = '0;
                if (pixel_tags.size() != 0)
                    tag = pixel_tags.pop_front();
                count_neighbours(s_axis_tdata[0], !tag.typed);
                if (tag.typed && tag.has_word)
                    count_expect_q.push_back(tag.word);
            end
        end
    end

    // Offer one pixel, with random idle cycles ahead of it.
    task automatic send_pixel(input logic px);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(px);
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pixels_sent++;
        @(negedge clk);
    endtask

    // Stop offering until every expected word is out, then let the block settle.
    task automatic wait_quiet(input int settle);
        s_axis_tvalid <= 1'b0;
        while (count_expect_q.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
        @(negedge clk);
    endtask

    // Main sequence.
    initial
    begin
        step_t          tag;
        logic [15:0]    w_val;
        logic [15:0]    h_val;
        int             phase_px;
        int             npx;
        int             pause_at;
        int             density;
        int             frames;
        int             wait_cycles;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_FRAME_WIDTH;
        cfg_data      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table.
        send_idle_pct  = 29;
        recv_stall_pct = 29;
        foreach (dir_steps[i])
        begin
            if (dir_steps[i].kind == STEP_WRITE)
            begin
                wait_quiet(SETTLE);
                write_reg(dir_steps[i].idx, dir_steps[i].data);
            end
            else
            begin
                pixel_tags.push_back(dir_steps[i]);
                send_pixel(dir_steps[i].px);
            end
        end

        // Random frames under four idle mixes.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            phase_px = 0;
            while (phase_px < PHASE_PIXELS)
            begin
                case ($urandom_range(9))
                    0: w_val = 16'($urandom_range(33, 63));
                    1: w_val = 16'(MAX_W);
                    2: w_val = 16'd0;
                    default: w_val = 16'($urandom_range(1, 8));
                endcase
                case ($urandom_range(7))
                    0: h_val = 16'd0;
                    1: h_val = 16'hFFFF;
                    2: h_val = 16'($urandom_range(6, 300));
                    default: h_val = 16'($urandom_range(1, 5));
                endcase
                wait_quiet(SETTLE);
                write_reg(REG_FRAME_WIDTH, w_val);
                write_reg(REG_FRAME_HEIGHT, h_val);

                // Hold the output off while the input keeps pushing.
                if ((phase == 0 || phase == 3) && phase_px == 0)
                    hold_requests++;

                frames = $urandom_range(1, 2);
                for (int f = 0; f < frames; f++)
                begin
                    npx = clamp_width(w_val[WIDTH_W-1:0]) * clamp_height(h_val);
                    // Frames of more than 128 pixels get cut short; some small ones are broken off.
                    if (npx > 128)
                        npx = $urandom_range(clamp_width(w_val[WIDTH_W-1:0]) + 1,
                                             3 * clamp_width(w_val[WIDTH_W-1:0]) + 2);
                    else if ($urandom_range(5) == 0)
                        npx = $urandom_range(1, npx);
                    pause_at = ($urandom_range(4) == 0) ? $urandom_range(0, npx - 1) : -1;
                    density  = $urandom_range(0, 100);
                    for (int i = 0; i < npx && phase_px < PHASE_PIXELS; i++)
                    begin
                        if (i == pause_at)
                            wait_quiet(0);
                        tag = '0;
                        pixel_tags.push_back(tag);
                        send_pixel($urandom_range(99) < density);
                        phase_px++;
                    end
                end
            end
        end

        // Drain, then give the block time to show any stray word.
        s_axis_tvalid <= 1'b0;
        wait_cycles = 0;
        while (count_expect_q.size() != 0 && wait_cycles < 5000)
        begin
            @(negedge clk);
            wait_cycles++;
        end
        repeat (4 * SETTLE) @(negedge clk);
        if (count_expect_q.size() != 0)
        begin
            $display("%0t: %0d expected words never arrived", $time, count_expect_q.size());
            error_count += count_expect_q.size();
        end

        $display("Ran %0d pixels through %0d register writes; %0d count words checked.",
                 pixels_sent, cfg_writes, words_checked);
        $display("Sizes 0 to 63 by 0 to 65535, long output hold-offs, %0d errors.",
                 error_count);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
src/bnc3_pkg.sv
src/binary_neighbour_count_3x3.sv
src/bnc3_checker.sv
tb/testbench.sv
